FILE: rtl/core/drvt_pkg.sv
// Package for the delayed RFI visibility tangent block: payload types,
// controller states, command/status structs, constants and the CORDIC table.
// No dependencies.
package drvt_pkg;

  localparam int unsigned CordicStagesDef = 24;
  localparam logic [31:0] GainQ30  = 32'd652032874;
  localparam logic [31:0] TwoPiQ29 = 32'd3373259426;
  localparam logic [16:0] ScaleRst = 17'd65536;

  typedef struct packed {
    logic [63:0]        amp_a;
    logic [63:0]        amp_b;
    logic [63:0]        amp_tangent_a;
    logic [63:0]        amp_tangent_b;
    logic signed [31:0] delay_a;
    logic signed [31:0] delay_b;
    logic signed [31:0] delay_tangent_a;
    logic signed [31:0] delay_tangent_b;
    logic [31:0]        frequency;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] grad_re;
    logic signed [31:0] grad_im;
    logic               saturated;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PROD, ST_SUM, ST_RATE1, ST_RATE2, ST_TERM, ST_CORDIC,
    ST_ROT, ST_ACC, ST_SCALE
  } state_t;

  typedef struct packed {
    logic load;
    logic prod;
    logic sum;
    logic rate1;
    logic rate2;
    logic term;
    logic cstart;
    logic cstep;
    logic rot;
    logic acc;
    logic scale;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic last;
  } sts_t;

  function automatic logic [31:0] atan_turns(input logic [4:0] k);
    logic [31:0] t;
    case (k)
      5'd0:  t = 32'h20000000; 5'd1:  t = 32'h12E4051E; 5'd2:  t = 32'h09FB385B;
      5'd3:  t = 32'h051111D4; 5'd4:  t = 32'h028B0D43; 5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E; 5'd7:  t = 32'h00517C55; 5'd8:  t = 32'h0028BE53;
      5'd9:  t = 32'h00145F2F; 5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518; 5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146; 5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005; 5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
      5'd30: t = 32'h00000001; default: t = 32'h00000000;
    endcase
    return t;
  endfunction

  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > 64'sd2147483647) r = 64'sd2147483647;
    else if (v < -64'sd2147483648) r = -64'sd2147483648;
    else r = v;
    return r;
  endfunction

endpackage

FILE: rtl/core/drvt_ctrl.sv
// Controller for the delayed RFI visibility tangent block.
// Sequences the datapath one step per state; depends on drvt_pkg.
module drvt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  drvt_pkg::sts_t  sts,
  output drvt_pkg::cmd_t  cmd
);
  import drvt_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // result register free, or emptied at this edge
  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_PROD;
      ST_PROD:   state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_RATE1;
      ST_RATE1:  state_nxt = ST_RATE2;
      ST_RATE2:  state_nxt = ST_TERM;
      ST_TERM:   state_nxt = ST_CORDIC;
      ST_CORDIC: if (sts.cordic_done) state_nxt = ST_ROT;
      ST_ROT:    state_nxt = ST_ACC;
      ST_ACC:    state_nxt = sts.last ? ST_SCALE : ST_IDLE;
      ST_SCALE:  if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE:   begin in_ready = 1'b1; cmd.load = in_valid; end
      ST_PROD:   cmd.prod = 1'b1;
      ST_SUM:    cmd.sum = 1'b1;
      ST_RATE1:  cmd.rate1 = 1'b1;
      ST_RATE2:  cmd.rate2 = 1'b1;
      ST_TERM:   begin cmd.term = 1'b1; cmd.cstart = 1'b1; end
      ST_CORDIC: cmd.cstep = 1'b1;
      ST_ROT:    cmd.rot = 1'b1;
      ST_ACC:    cmd.acc = 1'b1;
      ST_SCALE:  cmd.scale = slot_free;
      default:   ;
    endcase
  end

  // result valid flag, set when the scaled sum is captured
  assign out_valid_nxt = cmd.scale | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scale |-> slot_free) else $error("result overwritten");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_acc_after_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rot |=> cmd.acc) else $error("rotation not accumulated");
endmodule

FILE: rtl/core/drvt_dp.sv
// Datapath for the delayed RFI visibility tangent block: products, phase
// rate, iterative CORDIC, accumulator and output scaling. Depends on drvt_pkg.
module drvt_dp #(
  parameter int unsigned CORDIC_STAGES = drvt_pkg::CordicStagesDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  drvt_pkg::in_req_t   in_data,
  input  logic                cfg_valid,
  input  logic [16:0]         cfg_data,
  input  drvt_pkg::cmd_t      cmd,
  output drvt_pkg::sts_t      sts,
  output drvt_pkg::out_req_t  out_data
);
  import drvt_pkg::*;

  localparam int CntW = $clog2(CORDIC_STAGES + 1);

  in_req_t            req_r;
  logic [16:0]        scale_r;
  logic signed [63:0] sum_re_r, sum_im_r;
  // products of the first step, each rounded
  logic signed [63:0] p_r [12];
  logic signed [63:0] br_r, bi_r, tr_r, ti_r;
  logic [63:0]        mag_r;
  logic               ddneg_r;
  logic [31:0]        rate_r;
  logic signed [63:0] pd_r;
  logic [1:0]         q_r;
  logic signed [33:0] z_r;
  logic signed [33:0] x_r, y_r;
  logic [CntW-1:0]    cnt_r;
  logic signed [63:0] rot_r [4];
  out_req_t           out_r;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] p, input int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] hi(input logic [63:0] v);
    return $signed(v[63:32]);
  endfunction

  function automatic logic signed [31:0] lo(input logic [63:0] v);
    return $signed(v[31:0]);
  endfunction

  // scaled, saturated value, rounded on its magnitude, and clip for one output part
  function automatic logic [32:0] scl(input logic signed [63:0] v, input logic [16:0] sc,
                                      output logic clip);
    logic        neg;
    logic [63:0] mag, r;
    logic [32:0] res;
    neg = v[63];
    mag = neg ? (64'd0 - v) : v;
    r = (mag >> 16) * sc + ((({48'd0, mag[15:0]} * sc) + 64'h8000) >> 16);
    clip = 1'b0;
    if (neg) begin
      if (r > 64'h80000000) begin clip = 1'b1; res = 33'h180000000; end
      else res = 33'(64'd0 - r);
    end else begin
      if (r > 64'h7FFFFFFF) begin clip = 1'b1; res = 33'h07FFFFFFF; end
      else res = 33'(r);
    end
    return res;
  endfunction

  function automatic logic signed [63:0] sadd(input logic signed [63:0] s,
                                              input logic signed [63:0] c);
    logic signed [64:0] t;
    t = {s[63], s} + {c[63], c};
    if (t > 65'sh0_7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
    if (t < -65'sh0_8000000000000000) return 64'sh8000000000000000;
    return t[63:0];
  endfunction

  logic [31:0] phase;
  logic [31:0] ph_off;
  logic [4:0]  stg;
  logic signed [33:0] xs, ys, at;
  logic signed [33:0] c_v, s_v;
  logic [32:0] gr, gi;
  logic clr, cli;
  logic signed [32:0] dd;

  assign dd     = 33'(req_r.delay_tangent_a) - 33'(req_r.delay_tangent_b);
  assign phase  = 32'(req_r.frequency * 32'(req_r.delay_a - req_r.delay_b));
  assign ph_off = phase + 32'h20000000;
  // table index wraps modulo 32
  assign stg = 5'(cnt_r);
  assign xs = x_r >>> stg;
  assign ys = y_r >>> stg;
  assign at = $signed({2'b00, atan_turns(stg)});

  always_comb begin
    unique case (q_r)
      2'd0: begin c_v = x_r;  s_v = y_r;  end
      2'd1: begin c_v = -y_r; s_v = x_r;  end
      2'd2: begin c_v = -x_r; s_v = -y_r; end
      default: begin c_v = y_r; s_v = -x_r; end
    endcase
  end

  always_comb begin
    gr = scl(sum_re_r, scale_r, clr);
    gi = scl(sum_im_r, scale_r, cli);
  end

  assign sts.cordic_done = (cnt_r == CntW'(CORDIC_STAGES - 1));
  assign sts.last        = req_r.last;
  assign out_data        = out_r;

  // configuration and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= ScaleRst;
      sum_re_r <= '0;
      sum_im_r <= '0;
    end else begin
      if (cfg_valid) scale_r <= cfg_data;
      if (cmd.acc) begin
        sum_re_r <= sadd(sum_re_r, rot_r[0] - rot_r[1]);
        sum_im_r <= sadd(sum_im_r, rot_r[2] + rot_r[3]);
      end
      if (cmd.scale) begin
        sum_re_r <= '0;
        sum_im_r <= '0;
      end
    end
  end

  // payload steps
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    if (cmd.prod) begin
      p_r[0]  <= rnd(64'(hi(req_r.amp_a)) * hi(req_r.amp_b), 23);
      p_r[1]  <= rnd(64'(lo(req_r.amp_a)) * lo(req_r.amp_b), 23);
      p_r[2]  <= rnd(64'(lo(req_r.amp_a)) * hi(req_r.amp_b), 23);
      p_r[3]  <= rnd(64'(hi(req_r.amp_a)) * lo(req_r.amp_b), 23);
      p_r[4]  <= rnd(64'(hi(req_r.amp_tangent_a)) * hi(req_r.amp_b), 23);
      p_r[5]  <= rnd(64'(lo(req_r.amp_tangent_a)) * lo(req_r.amp_b), 23);
      p_r[6]  <= rnd(64'(lo(req_r.amp_tangent_a)) * hi(req_r.amp_b), 23);
      p_r[7]  <= rnd(64'(hi(req_r.amp_tangent_a)) * lo(req_r.amp_b), 23);
      p_r[8]  <= rnd(64'(hi(req_r.amp_a)) * hi(req_r.amp_tangent_b), 23);
      p_r[9]  <= rnd(64'(lo(req_r.amp_a)) * lo(req_r.amp_tangent_b), 23);
      p_r[10] <= rnd(64'(lo(req_r.amp_a)) * hi(req_r.amp_tangent_b), 23);
      p_r[11] <= rnd(64'(hi(req_r.amp_a)) * lo(req_r.amp_tangent_b), 23);
      ddneg_r <= dd[32];
      mag_r   <= {32'd0, req_r.frequency} *
                 {31'd0, (dd[32] ? 33'(-dd) : dd)};
    end
    if (cmd.sum) begin
      br_r <= sat32(p_r[0] + p_r[1]);
      bi_r <= sat32(p_r[2] - p_r[3]);
      tr_r <= sat32(p_r[4] + p_r[5] + p_r[8] + p_r[9]);
      ti_r <= sat32(p_r[6] - p_r[7] + p_r[10] - p_r[11]);
    end
    // phase rate: round to Q.16 turns, then times 2*pi
    if (cmd.rate1) begin
      if (((mag_r + 64'h8000) >> 16) >= 64'h80000000) rate_r <= 32'h7FFFFFFF;
      else begin
        rate_r <= 32'(((mag_r + 64'h8000) >> 16));
        mag_r  <= 64'hFFFF_FFFF_FFFF_FFFF;
      end
    end
    if (cmd.rate2) begin
      if (mag_r != 64'hFFFF_FFFF_FFFF_FFFF) pd_r <= ddneg_r ? -64'sd2147483647
                                                            : 64'sd2147483647;
      else begin
        logic [63:0] r;
        r = (({32'd0, rate_r} * TwoPiQ29) + 64'h10000000) >> 29;
        if (r > 64'h7FFFFFFF) r = 64'h7FFFFFFF;
        pd_r <= ddneg_r ? -$signed(r) : $signed(r);
      end
    end
    // rate and base both fit 32 bits
    if (cmd.term) begin
      tr_r <= sat32(tr_r - rnd(64'($signed(pd_r[31:0])) * $signed(bi_r[31:0]), 16));
      ti_r <= sat32(ti_r + rnd(64'($signed(pd_r[31:0])) * $signed(br_r[31:0]), 16));
    end
    // iterative CORDIC, one stage per cycle
    if (cmd.cstart) begin
      q_r   <= ph_off[31:30];
      z_r   <= 34'($signed(phase - {ph_off[31:30], 30'd0}));
      x_r   <= $signed({2'b00, GainQ30});
      y_r   <= '0;
      cnt_r <= '0;
    end else if (cmd.cstep) begin
      if (!z_r[33]) begin
        x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + at;
      end
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.rot) begin
      rot_r[0] <= rnd(64'(c_v) * $signed(tr_r[31:0]), 30);
      rot_r[1] <= rnd(64'(s_v) * $signed(ti_r[31:0]), 30);
      rot_r[2] <= rnd(64'(c_v) * $signed(ti_r[31:0]), 30);
      rot_r[3] <= rnd(64'(s_v) * $signed(tr_r[31:0]), 30);
    end
    if (cmd.scale) begin
      out_r.grad_re   <= gr[31:0];
      out_r.grad_im   <= gi[31:0];
      out_r.saturated <= clr | cli;
    end
  end

  a_cstep_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cstep && !sts.cordic_done) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("cordic counter slipped");
  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scale |=> (sum_re_r == 0 && sum_im_r == 0)) else $error("sum not cleared");
  a_scale_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_valid |=> $stable(scale_r)) else $error("scale changed");
endmodule

FILE: rtl/core/delayed_rfi_visibility_tangent.sv
// Top level of the delayed RFI visibility tangent block.
// Joins drvt_ctrl and drvt_dp; depends on drvt_pkg.
//
//  channel | ports                   | dir | content
//  in      | in_valid/in_ready/in_data   | in  | one sample
//  out     | out_valid/out_ready/out_data| out | scaled sum on last
//  cfg     | cfg_valid/cfg_ready/cfg_data| in  | scale, Q1.16
//
// Each sample runs through the single shared CORDIC stage, which iterates
// once per cycle; a new sample is taken only when the block is back in idle.
// Reset (rst_n, synchronous) clears the sum and sets scale to 1.0.
// A result waits in the output register while samples go on; a later last
// sample stalls in its scale step until out_ready takes it. cfg is always ready.
module delayed_rfi_visibility_tangent #(
  parameter int unsigned CORDIC_STAGES = drvt_pkg::CordicStagesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  drvt_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output drvt_pkg::out_req_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [16:0]        cfg_data
);
  import drvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  drvt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  drvt_dp #(.CORDIC_STAGES(CORDIC_STAGES)) u_dp (
    .clk, .rst_n, .in_data, .cfg_valid, .cfg_data, .cmd, .sts, .out_data
  );
endmodule
